// ----- rtl/core/slpl_pkg.sv -----
// Shared types, constants and helper functions for the stereo lookahead peak limiter.
// Used by every module of the limiter core; depends on nothing else.
package slpl_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int MAX_DELAY   = 512;
	localparam int ADDR_W      = $clog2(MAX_DELAY);
	localparam int FILL_W      = ADDR_W + 1;
	localparam int RC_W        = 24;
	localparam int LEN_W       = 10;
	localparam int CNT_W       = (LEN_W > FILL_W) ? LEN_W : FILL_W;
	localparam int MUL_W       = (SAMPLE_BITS > RC_W) ? SAMPLE_BITS : RC_W;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int DIV_STEPS   = SAMPLE_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [MUL_W-1:0]       mul_op_t;
	typedef logic [PROD_W-1:0]      prod_t;

	localparam sample_t UNITY          = sample_t'(1) << FRAC_BITS;
	localparam sample_t CEILING_RESET  = sample_t'(8103822);
	localparam logic [RC_W-1:0]  RELEASE_RESET = RC_W'(4660);
	localparam logic [LEN_W-1:0] DELAY_RESET   = LEN_W'(97);

	typedef enum logic [1:0] {
		REG_CEILING = 2'd0,
		REG_RELEASE = 2'd1,
		REG_DELAY   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV1,
		ST_REL,
		ST_GAIN,
		ST_DIV2,
		ST_MULL,
		ST_MULR,
		ST_FIN
	} state_t;

	// Magnitude of a two's complement sample; the most negative code maps to 2^FRAC_BITS.
	function automatic sample_t magnitude(input sample_t s);
		magnitude = s[SAMPLE_BITS-1] ? (~s + sample_t'(1)) : s;
	endfunction

	// Takes a magnitude times gain product back to Q1.x and restores the sign.
	function automatic sample_t scale_out(input prod_t p, input logic neg);
		sample_t m;
		m = p[FRAC_BITS +: SAMPLE_BITS];
		scale_out = neg ? (sample_t'(0) - m) : m;
	endfunction

endpackage

// ----- rtl/core/slpl_div.sv -----
// Restoring divider computing (ceiling << FRAC_BITS) / divisor, one quotient bit per cycle.
// Depends on slpl_pkg; the caller guarantees divisor is above the ceiling.
module slpl_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  slpl_pkg::sample_t    ceiling,
	input  slpl_pkg::sample_t    divisor,
	output slpl_pkg::sample_t    quotient,
	output logic                 done
);

	logic [slpl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	slpl_pkg::sample_t              rem_q;
	slpl_pkg::sample_t              low_q;
	slpl_pkg::sample_t              div_q;
	slpl_pkg::sample_t              quot_q;
	logic [slpl_pkg::SAMPLE_BITS+1:0] diff;

	assign diff = {1'b0, rem_q, low_q[slpl_pkg::SAMPLE_BITS-1]} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= slpl_pkg::DIV_CNT_W'(slpl_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == slpl_pkg::DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// The shifted dividend is split into an upper part that seeds the remainder and
	// a lower part that is shifted in one bit per step.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= ceiling >> 1;
			low_q  <= {ceiling[0], {(slpl_pkg::SAMPLE_BITS-1){1'b0}}};
			div_q  <= divisor;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			low_q <= low_q << 1;
			if (!diff[slpl_pkg::SAMPLE_BITS+1]) begin
				rem_q  <= diff[slpl_pkg::SAMPLE_BITS-1:0];
				quot_q <= {quot_q[slpl_pkg::SAMPLE_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[slpl_pkg::SAMPLE_BITS-2:0], low_q[slpl_pkg::SAMPLE_BITS-1]};
				quot_q <= {quot_q[slpl_pkg::SAMPLE_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

// ----- rtl/core/slpl_mult.sv -----
// Shared registered multiplier used for the release step and both sample scalings.
// Depends on slpl_pkg for operand and product widths.
module slpl_mult (
	input  logic              clk,
	input  logic              en,
	input  slpl_pkg::mul_op_t a,
	input  slpl_pkg::mul_op_t b,
	output slpl_pkg::prod_t   prod
);

	slpl_pkg::prod_t prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= slpl_pkg::prod_t'(a) * slpl_pkg::prod_t'(b);
		end
	end

	assign prod = prod_q;

endmodule

// ----- rtl/core/slpl_delay_line.sv -----
// Lookahead delay line: one stereo memory, write position and a fill count.
// Depends on slpl_pkg; entries at or above the fill count read as zero.
module slpl_delay_line (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  slpl_pkg::sample_t                  wr_left,
	input  slpl_pkg::sample_t                  wr_right,
	input  logic [slpl_pkg::LEN_W-1:0]         delay_length,
	output slpl_pkg::sample_t                  rd_left,
	output slpl_pkg::sample_t                  rd_right
);

	logic [2*slpl_pkg::SAMPLE_BITS-1:0] mem [slpl_pkg::MAX_DELAY];
	logic [2*slpl_pkg::SAMPLE_BITS-1:0] rd_q;
	logic                               rd_valid_q;
	logic [slpl_pkg::ADDR_W-1:0]        pos_q;
	logic [slpl_pkg::FILL_W-1:0]        fill_q;
	logic [slpl_pkg::CNT_W-1:0]         len_raw;
	logic [slpl_pkg::CNT_W-1:0]         len_eff;
	logic [slpl_pkg::CNT_W-1:0]         next_pos;

	assign len_raw  = slpl_pkg::CNT_W'(delay_length);
	assign next_pos = slpl_pkg::CNT_W'(pos_q) + slpl_pkg::CNT_W'(1);

	always_comb begin
		if (len_raw == '0) begin
			len_eff = slpl_pkg::CNT_W'(1);
		end else if (len_raw > slpl_pkg::CNT_W'(slpl_pkg::MAX_DELAY)) begin
			len_eff = slpl_pkg::CNT_W'(slpl_pkg::MAX_DELAY);
		end else begin
			len_eff = len_raw;
		end
	end

	// Read and write share one address; the read returns the entry before the write.
	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q        <= mem[pos_q];
			mem[pos_q]  <= {wr_left, wr_right};
		end
	end

	// Positions are always visited upward from zero, so the written entries are
	// exactly those up to and including the highest position ever reached.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			fill_q     <= '0;
			rd_valid_q <= 1'b0;
		end else if (advance) begin
			rd_valid_q <= slpl_pkg::FILL_W'(pos_q) < fill_q;
			if (slpl_pkg::FILL_W'(pos_q) == fill_q) begin
				fill_q <= fill_q + 1'b1;
			end
			pos_q <= (next_pos < len_eff) ? slpl_pkg::ADDR_W'(next_pos) : '0;
		end
	end

	assign rd_left  = rd_valid_q ? rd_q[2*slpl_pkg::SAMPLE_BITS-1:slpl_pkg::SAMPLE_BITS] : '0;
	assign rd_right = rd_valid_q ? rd_q[slpl_pkg::SAMPLE_BITS-1:0] : '0;

endmodule

// ----- rtl/core/stereo_lookahead_peak_limiter_core.sv -----
// A request passes PREP, REL, GAIN, MULL, MULR and FIN, with a division after PREP
// when the new frame peak exceeds the ceiling and after GAIN when the delayed one
// does; each division runs on the one shared 24-step divider. A new request is
// taken the cycle after the result enters the output register.
// Reset clears the sequencer, the registers to their defaults, the gain to unity
// and the delay line fill count; the delay memory itself is never swept.
module stereo_lookahead_peak_limiter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slpl_pkg::APB_AW-1:0]   paddr,
	input  logic [slpl_pkg::APB_DW-1:0]   pwdata,
	output logic [slpl_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [23:0]            left_sample,
	input  logic signed [23:0]            right_sample,
	input  logic                          end_of_block,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [23:0]            left_out,
	output logic signed [23:0]            right_out,
	output logic [23:0]                   applied_gain,
	output logic                          block_end_out
);

	slpl_pkg::state_t             state_q, state_d;
	slpl_pkg::sample_t            ceil_q;
	logic [slpl_pkg::RC_W-1:0]    rel_q;
	logic [slpl_pkg::LEN_W-1:0]   len_q;
	slpl_pkg::reg_idx_t           reg_idx;
	logic                         cfg_wr;

	slpl_pkg::sample_t            peak_q, dpeak_q, target_q, gain_q, og_q, left_res_q;
	logic                         eob_q;
	slpl_pkg::sample_t            gain_d, dpeak_d;
	slpl_pkg::sample_t            dl, dr;
	logic                         accept, out_free;

	logic                         div_start, div_done;
	slpl_pkg::sample_t            div_divisor, quotient;
	logic                         mul_en;
	slpl_pkg::mul_op_t            mul_a, mul_b;
	slpl_pkg::prod_t              prod;

	logic                         out_valid_q, eob_out_q;
	slpl_pkg::sample_t            left_out_q, right_out_q, gain_out_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = slpl_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q <= slpl_pkg::CEILING_RESET;
			rel_q  <= slpl_pkg::RELEASE_RESET;
			len_q  <= slpl_pkg::DELAY_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				slpl_pkg::REG_CEILING: ceil_q <= pwdata[slpl_pkg::SAMPLE_BITS-1:0];
				slpl_pkg::REG_RELEASE: rel_q  <= pwdata[slpl_pkg::RC_W-1:0];
				slpl_pkg::REG_DELAY:   len_q  <= pwdata[slpl_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			slpl_pkg::REG_CEILING: prdata = slpl_pkg::APB_DW'(ceil_q);
			slpl_pkg::REG_RELEASE: prdata = slpl_pkg::APB_DW'(rel_q);
			slpl_pkg::REG_DELAY:   prdata = slpl_pkg::APB_DW'(len_q);
			default:               prdata = '0;
		endcase
	end

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	slpl_delay_line u_delay (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.wr_left      (left_sample),
		.wr_right     (right_sample),
		.delay_length (len_q),
		.rd_left      (dl),
		.rd_right     (dr)
	);

	slpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.ceiling  (ceil_q),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	slpl_mult u_mult (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slpl_pkg::ST_IDLE: if (in_valid) state_d = slpl_pkg::ST_PREP;
			slpl_pkg::ST_PREP: state_d = (peak_q > ceil_q) ? slpl_pkg::ST_DIV1 : slpl_pkg::ST_REL;
			slpl_pkg::ST_DIV1: if (div_done) state_d = slpl_pkg::ST_REL;
			slpl_pkg::ST_REL:  state_d = slpl_pkg::ST_GAIN;
			slpl_pkg::ST_GAIN: state_d = (dpeak_q > ceil_q) ? slpl_pkg::ST_DIV2 : slpl_pkg::ST_MULL;
			slpl_pkg::ST_DIV2: if (div_done) state_d = slpl_pkg::ST_MULL;
			slpl_pkg::ST_MULL: state_d = slpl_pkg::ST_MULR;
			slpl_pkg::ST_MULR: state_d = slpl_pkg::ST_FIN;
			slpl_pkg::ST_FIN:  if (out_free) state_d = slpl_pkg::ST_IDLE;
			default:           state_d = slpl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, divider start and multiplier operand selection.
	always_comb begin
		in_stall    = 1'b1;
		div_start   = 1'b0;
		div_divisor = dpeak_q;
		mul_en      = 1'b0;
		mul_a       = slpl_pkg::mul_op_t'(slpl_pkg::magnitude(dl));
		mul_b       = slpl_pkg::mul_op_t'(og_q);
		unique case (state_q)
			slpl_pkg::ST_IDLE: in_stall = 1'b0;
			slpl_pkg::ST_PREP: begin
				div_start   = peak_q > ceil_q;
				div_divisor = peak_q;
			end
			slpl_pkg::ST_REL: begin
				mul_en = 1'b1;
				mul_a  = slpl_pkg::mul_op_t'(slpl_pkg::UNITY - gain_q);
				mul_b  = slpl_pkg::mul_op_t'(rel_q);
			end
			slpl_pkg::ST_GAIN: div_start = dpeak_q > ceil_q;
			slpl_pkg::ST_MULL: mul_en = 1'b1;
			slpl_pkg::ST_MULR: begin
				mul_en = 1'b1;
				mul_a  = slpl_pkg::mul_op_t'(slpl_pkg::magnitude(dr));
			end
			default: ;
		endcase
	end

	always_comb begin
		if (target_q < gain_q) begin
			gain_d = target_q;
		end else begin
			gain_d = gain_q + prod[slpl_pkg::RC_W +: slpl_pkg::SAMPLE_BITS];
		end
	end

	always_comb begin
		if (slpl_pkg::magnitude(dl) > slpl_pkg::magnitude(dr)) begin
			dpeak_d = slpl_pkg::magnitude(dl);
		end else begin
			dpeak_d = slpl_pkg::magnitude(dr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slpl_pkg::ST_IDLE;
			gain_q  <= slpl_pkg::UNITY;
		end else begin
			state_q <= state_d;
			if (state_q == slpl_pkg::ST_GAIN) begin
				gain_q <= gain_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eob_q <= end_of_block;
			if (slpl_pkg::magnitude(left_sample) > slpl_pkg::magnitude(right_sample)) begin
				peak_q <= slpl_pkg::magnitude(left_sample);
			end else begin
				peak_q <= slpl_pkg::magnitude(right_sample);
			end
		end
		unique case (state_q)
			slpl_pkg::ST_PREP: begin
				dpeak_q  <= dpeak_d;
				target_q <= slpl_pkg::UNITY;
			end
			slpl_pkg::ST_DIV1: if (div_done) target_q <= quotient;
			slpl_pkg::ST_GAIN: og_q <= gain_d;
			slpl_pkg::ST_DIV2: if (div_done && quotient < og_q) og_q <= quotient;
			slpl_pkg::ST_MULR: left_res_q <= slpl_pkg::scale_out(prod, dl[slpl_pkg::SAMPLE_BITS-1]);
			default: ;
		endcase
	end

	// Output register; it frees the sequencer while a result waits to be taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == slpl_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == slpl_pkg::ST_FIN && out_free) begin
			left_out_q  <= left_res_q;
			right_out_q <= slpl_pkg::scale_out(prod, dr[slpl_pkg::SAMPLE_BITS-1]);
			gain_out_q  <= og_q;
			eob_out_q   <= eob_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_out      = left_out_q;
	assign right_out     = right_out_q;
	assign applied_gain  = gain_out_q;
	assign block_end_out = eob_out_q;

endmodule

// ----- rtl/core/slpl_checker.sv -----
// Port-level checks for the limiter core, bound onto the top level.
// Depends on slpl_pkg and on stereo_lookahead_peak_limiter_core's ports.
module slpl_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic signed [23:0]   left_out,
	input logic signed [23:0]   right_out,
	input logic [23:0]          applied_gain,
	input logic                 block_end_out
);

	// A result waiting under stall stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out)
			&& $stable(applied_gain) && $stable(block_end_out))
		else $error("stalled result changed");

	// Once a request is taken the core is busy with it.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while the previous one is in progress");

	// The result of a request never appears in the cycle right after it.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

	// The gain never exceeds unity.
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> applied_gain <= slpl_pkg::UNITY)
		else $error("applied gain above unity");

endmodule

bind stereo_lookahead_peak_limiter_core slpl_checker u_slpl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.left_out      (left_out),
	.right_out     (right_out),
	.applied_gain  (applied_gain),
	.block_end_out (block_end_out)
);
